/* design/jos_pkg.sv */
// Shared types and constants for the JSON object splitter.
package jos_pkg;

  // Width of the brace nesting counter.
  localparam int unsigned NestBits = 8;

  typedef logic [NestBits-1:0] depth_t;
  typedef logic [7:0]          byte_t;

  localparam depth_t DepthMax = {NestBits{1'b1}};

  localparam byte_t ChOpen   = 8'h7B;
  localparam byte_t ChClose  = 8'h7D;
  localparam byte_t ChQuote  = 8'h22;
  localparam byte_t ChBslash = 8'h5C;
  localparam byte_t ChSpace  = 8'h20;
  localparam byte_t ChLf     = 8'h0A;
  localparam byte_t ChCr     = 8'h0D;
  localparam byte_t ChTab    = 8'h09;

  typedef enum logic [1:0] {
    ModeBetween = 2'd0,
    ModeObject  = 2'd1,
    ModeString  = 2'd2,
    ModeError   = 2'd3
  } scan_mode_e;

endpackage

/* design/json_object_splitter.sv */
// Top level of the JSON object splitter: byte scanner with a registered result stage.

// The splitter takes one byte of a text stream per transaction and passes on the
// bytes of each top-level JSON object, marking the opening brace with object_first_o
// and the closing brace that ends the object with object_last_o. Whitespace between
// objects is dropped and produces no result. Brace nesting is counted only outside
// strings, and a backslash inside a string makes the following byte literal, even
// when that byte arrives much later. Any other byte between objects, or an opening
// brace that would overflow the nesting counter, produces one result with
// error_flag_o set (out_byte_o then holds the offending byte), after which every
// byte is consumed silently until reset. The scan state update is a short piece of
// logic feeding a single result register, so a new byte is accepted every cycle as
// long as the result register is empty or is being emptied in the same cycle. The
// result is valid in the cycle after its byte is accepted.
module json_object_splitter import jos_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  byte_t in_byte_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output byte_t out_byte_o,
  output logic  object_first_o,
  output logic  object_last_o,
  output logic  error_flag_o
);

  scan_mode_e mode_q, mode_d;
  logic       esc_q, esc_d;
  depth_t     depth_q, depth_d;

  logic  out_valid_q;
  byte_t out_byte_q;
  logic  first_q, last_q, err_q;

  logic res_valid, res_first, res_last, res_err;
  logic accept, is_blank;

  // The result register is free when it is empty or being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_blank = (in_byte_i == ChSpace) || (in_byte_i == ChLf) ||
                    (in_byte_i == ChCr)    || (in_byte_i == ChTab);

  // Next scan state.
  always_comb begin
    mode_d  = mode_q;
    esc_d   = esc_q;
    depth_d = depth_q;
    unique case (mode_q)
      ModeBetween: begin
        if (in_byte_i == ChOpen) begin
          mode_d  = ModeObject;
          esc_d   = 1'b0;
          depth_d = depth_t'(1);
        end else if (!is_blank) begin
          mode_d = ModeError;
        end
      end
      ModeObject: begin
        if (in_byte_i == ChOpen) begin
          if (depth_q == DepthMax) begin
            mode_d = ModeError;
          end else begin
            depth_d = depth_q + depth_t'(1);
          end
        end else if (in_byte_i == ChClose) begin
          // An object always holds at least depth one here.
          if (depth_q != '0) begin
            depth_d = depth_q - depth_t'(1);
          end
          if (depth_q <= depth_t'(1)) begin
            mode_d = ModeBetween;
          end
        end else if (in_byte_i == ChQuote) begin
          mode_d = ModeString;
          esc_d  = 1'b0;
        end
      end
      ModeString: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (in_byte_i == ChBslash) begin
          esc_d = 1'b1;
        end else if (in_byte_i == ChQuote) begin
          mode_d = ModeObject;
        end
      end
      ModeError: begin
        mode_d = ModeError;
      end
      default: begin
        mode_d = ModeError;
      end
    endcase
  end

  // Result produced by the current byte.
  always_comb begin
    res_valid = 1'b0;
    res_first = 1'b0;
    res_last  = 1'b0;
    res_err   = 1'b0;
    unique case (mode_q)
      ModeBetween: begin
        if (in_byte_i == ChOpen) begin
          res_valid = 1'b1;
          res_first = 1'b1;
        end else if (!is_blank) begin
          res_valid = 1'b1;
          res_err   = 1'b1;
        end
      end
      ModeObject: begin
        res_valid = 1'b1;
        if (in_byte_i == ChOpen && depth_q == DepthMax) begin
          res_err = 1'b1;
        end else if (in_byte_i == ChClose && depth_q <= depth_t'(1)) begin
          res_last = 1'b1;
        end
      end
      ModeString: begin
        res_valid = 1'b1;
      end
      ModeError: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeBetween;
      esc_q       <= 1'b0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        esc_q   <= esc_d;
        depth_q <= depth_d;
      end
      if (in_ready_o) begin
        out_valid_q <= accept && res_valid;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_byte_q <= in_byte_i;
      first_q    <= res_first;
      last_q     <= res_last;
      err_q      <= res_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign object_first_o = first_q;
  assign object_last_o  = last_q;
  assign error_flag_o   = err_q;

  // Error results never carry object marks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> !object_first_o && !object_last_o)
    else $error("error result carries an object mark");

  // Error mode is sticky until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeError |=> mode_q == ModeError)
    else $error("scanner left error mode");

  // A pending escape exists only inside a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> mode_q == ModeString)
    else $error("escape pending outside a string");

  // Inside an object or string the nesting depth is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeObject || mode_q == ModeString) |-> depth_q != '0)
    else $error("zero nesting depth inside an object");

  // An error result always moves the scanner into error mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid && res_err |=> mode_q == ModeError)
    else $error("error result without error mode");

endmodule
